// ----- sv/telemetry_frame_parser_core_assert.svh -----
// ----------------------------------------------------------------------------
// Telemetry frame parser assertion macros
// Clocked, reset-gated property wrappers shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_PARSER_CORE_ASSERT_SVH
`define TELEMETRY_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TFP_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("telemetry frame parser: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("telemetry frame parser: next-cycle check failed");

`endif

// ----- sv/tfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Telemetry frame parser package
// Frame layout, field codes, result item type and result queue sizing.
// ----------------------------------------------------------------------------
package tfp_pkg;

    localparam int NUM_LEGS       = 5;
    localparam int JOINTS_PER_LEG = 4;
    localparam int NUM_ANGLES     = NUM_LEGS * JOINTS_PER_LEG;

    // Byte offsets within a frame (magic byte at 0)
    localparam int POS_W = 7;
    localparam logic [POS_W-1:0] POS_MAGIC  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_STATUS = POS_W'(1);
    localparam logic [POS_W-1:0] POS_ANGLE  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DIST   = POS_W'(2 + 2 * NUM_ANGLES);
    localparam logic [POS_W-1:0] POS_SERVO  = POS_W'(2 + 2 * NUM_ANGLES + NUM_LEGS);
    localparam logic [POS_W-1:0] POS_IMUX   =
        POS_W'(2 + 2 * NUM_ANGLES + NUM_LEGS + NUM_ANGLES / 2);
    localparam logic [POS_W-1:0] POS_LOOP   =
        POS_W'(2 + 2 * NUM_ANGLES + NUM_LEGS + NUM_ANGLES / 2 + 8);
    localparam logic [POS_W-1:0] POS_SUM    =
        POS_W'(2 + 2 * NUM_ANGLES + NUM_LEGS + NUM_ANGLES / 2 + 9);

    localparam logic [7:0]  XOR_SEED    = 8'hFE;
    localparam logic [15:0] WORD_OFFSET = 16'h8000;

    typedef enum logic [3:0] {
        KIND_STATUS = 4'd0,
        KIND_ANGLE  = 4'd1,
        KIND_DIST   = 4'd2,
        KIND_SERVO  = 4'd3,
        KIND_IMUX   = 4'd4,
        KIND_IMUY   = 4'd5,
        KIND_IMUS   = 4'd6,
        KIND_VOLT   = 4'd7,
        KIND_LOOP   = 4'd8,
        KIND_END    = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        FST_OK        = 2'd0,
        FST_BAD_MAGIC = 2'd1,
        FST_BAD_SUM   = 2'd2
    } fstat_t;

    typedef struct packed {
        kind_t              kind;
        logic [4:0]         index;
        logic signed [15:0] value;
        fstat_t             status;
        logic               last;
    } result_t;

    // Result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        logic                 not_empty;
        logic                 room2;     // space for a two-result byte
    } fifo_stat_t;

endpackage

// ----- sv/tfp_frame_decode.sv -----
// ----------------------------------------------------------------------------
// Telemetry frame decoder
// Frame position, running XOR and held high byte; turns one byte into up to
// two result items.
// ----------------------------------------------------------------------------
module tfp_frame_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          magic_value,
    input  logic [7:0]          in_byte,
    input  logic                fire,
    output logic [1:0]          wr_cnt,
    output tfp_pkg::result_t    res0,
    output tfp_pkg::result_t    res1
);

    logic [tfp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                xor_reg, xor_next;
    logic [7:0]                held_reg, held_next;
    logic [1:0]                n_res;

    always_comb
    begin
        logic [tfp_pkg::POS_W-1:0] off_a;
        logic [tfp_pkg::POS_W-1:0] off_d;
        logic [tfp_pkg::POS_W-1:0] off_s;
        logic [tfp_pkg::POS_W-1:0] off_i;
        logic [15:0]               word;

        off_a = pos_reg - tfp_pkg::POS_ANGLE;
        off_d = pos_reg - tfp_pkg::POS_DIST;
        off_s = pos_reg - tfp_pkg::POS_SERVO;
        off_i = pos_reg - tfp_pkg::POS_IMUX;
        word  = {held_reg, in_byte} ^ tfp_pkg::WORD_OFFSET;

        pos_next  = pos_reg;
        xor_next  = xor_reg;
        held_next = held_reg;
        n_res     = 2'd1;

        res0.kind   = tfp_pkg::KIND_END;
        res0.index  = '0;
        res0.value  = '0;
        res0.status = tfp_pkg::FST_OK;
        res0.last   = 1'b1;
        res1        = res0;

        if (pos_reg == tfp_pkg::POS_MAGIC)
        begin
            if (in_byte != magic_value)
            begin
                res0.status = tfp_pkg::FST_BAD_MAGIC;
                xor_next    = tfp_pkg::XOR_SEED;
            end
            else
            begin
                xor_next = tfp_pkg::XOR_SEED ^ in_byte;
                pos_next = tfp_pkg::POS_STATUS;
                n_res    = 2'd0;
            end
        end
        else if (pos_reg >= tfp_pkg::POS_SUM)
        begin
            res0.status = (in_byte == xor_reg) ? tfp_pkg::FST_OK : tfp_pkg::FST_BAD_SUM;
            pos_next    = tfp_pkg::POS_MAGIC;
            xor_next    = tfp_pkg::XOR_SEED;
        end
        else
        begin
            xor_next = xor_reg ^ in_byte;
            pos_next = pos_reg + tfp_pkg::POS_W'(1);
            if (pos_reg == tfp_pkg::POS_STATUS)
            begin
                res0.kind  = tfp_pkg::KIND_STATUS;
                res0.value = {{8{in_byte[7]}}, in_byte};
            end
            else if (pos_reg < tfp_pkg::POS_DIST)
            begin
                if (!off_a[0])
                begin
                    held_next = in_byte;
                    n_res     = 2'd0;
                end
                else
                begin
                    res0.kind  = tfp_pkg::KIND_ANGLE;
                    res0.index = off_a[5:1];
                    res0.value = word;
                end
            end
            else if (pos_reg < tfp_pkg::POS_SERVO)
            begin
                res0.kind  = tfp_pkg::KIND_DIST;
                res0.index = off_d[4:0];
                res0.value = {8'd0, in_byte};
            end
            else if (pos_reg < tfp_pkg::POS_IMUX)
            begin
                // low nibble first, then high nibble, both unsigned
                res0.kind  = tfp_pkg::KIND_SERVO;
                res0.index = {off_s[3:0], 1'b0};
                res0.value = {12'd0, in_byte[3:0]};
                res0.last  = 1'b0;
                res1.kind  = tfp_pkg::KIND_SERVO;
                res1.index = {off_s[3:0], 1'b1};
                res1.value = {12'd0, in_byte[7:4]};
                n_res      = 2'd2;
            end
            else if (pos_reg < tfp_pkg::POS_LOOP)
            begin
                if (!off_i[0])
                begin
                    held_next = in_byte;
                    n_res     = 2'd0;
                end
                else
                begin
                    case (off_i[2:1])
                        2'd0:    res0.kind = tfp_pkg::KIND_IMUX;
                        2'd1:    res0.kind = tfp_pkg::KIND_IMUY;
                        2'd2:    res0.kind = tfp_pkg::KIND_IMUS;
                        default: res0.kind = tfp_pkg::KIND_VOLT;
                    endcase
                    res0.value = word;
                end
            end
            else
            begin
                res0.kind  = tfp_pkg::KIND_LOOP;
                res0.value = {8'd0, in_byte};
            end
        end
    end

    assign wr_cnt = fire ? n_res : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= tfp_pkg::POS_MAGIC;
            xor_reg  <= tfp_pkg::XOR_SEED;
            held_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg  <= pos_next;
            xor_reg  <= xor_next;
            held_reg <= held_next;
        end
    end

endmodule

// ----- sv/tfp_result_fifo.sv -----
// ----------------------------------------------------------------------------
// Telemetry frame parser result queue
// Small queue of result items; takes up to two items per cycle, gives one.
// ----------------------------------------------------------------------------
module tfp_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            wr_cnt,
    input  tfp_pkg::result_t      wr0,
    input  tfp_pkg::result_t      wr1,
    input  logic                  pop,
    output tfp_pkg::result_t      head,
    output tfp_pkg::fifo_stat_t   stat
);

    tfp_pkg::result_t                mem_reg [tfp_pkg::RES_DEPTH];
    logic [tfp_pkg::RES_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tfp_pkg::RES_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tfp_pkg::RES_CNT_W-1:0]   count_reg, count_next;
    logic [tfp_pkg::RES_PTR_W-1:0]   wr_ptr_p1;

    assign wr_ptr_p1   = wr_ptr_reg + tfp_pkg::RES_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + tfp_pkg::RES_PTR_W'(wr_cnt);
    assign rd_ptr_next = rd_ptr_reg + tfp_pkg::RES_PTR_W'(pop);
    assign count_next  = count_reg + tfp_pkg::RES_CNT_W'(wr_cnt)
                         - tfp_pkg::RES_CNT_W'(pop);

    assign head           = mem_reg[rd_ptr_reg];
    assign stat.count     = count_reg;
    assign stat.not_empty = (count_reg != '0);
    assign stat.room2     = (count_reg <= tfp_pkg::RES_CNT_W'(tfp_pkg::RES_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr0;
        end
        if (wr_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= wr1;
        end
    end

endmodule

// ----- sv/telemetry_frame_parser_core.sv -----
// Flow: a taken byte is held in the input register, decoded once the queue has room, and
//   its items are queued for the port. Bytes that only hold a high byte give no result.
// Throughput: one byte per cycle while the queue has room for two items; a servo-status
//   byte gives two items for the single output port, so runs of them back up the queue.
// Reset (rst_n, async, low): empty pipeline, frame position back to the magic byte,
//   checksum seed 0xFE, held byte and magic register zero.
// ----------------------------------------------------------------------------
// Telemetry frame parser top level
// Byte-serial telemetry frame parser: input register, frame decoder and a
// small result queue in front of the output port.
// ----------------------------------------------------------------------------
`include "telemetry_frame_parser_core_assert.svh"

module telemetry_frame_parser_core (
    input  logic               clk,
    input  logic               rst_n,
    // configuration: magic byte
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    // received bytes
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    // decoded result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         field_kind,
    output logic [4:0]         field_index,
    output logic signed [15:0] field_value,
    output logic [1:0]         frame_status,
    output logic               result_last
);

    logic [7:0]            magic_value_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  fire;
    logic                  pop;
    logic [1:0]            wr_cnt;
    tfp_pkg::result_t      res0;
    tfp_pkg::result_t      res1;
    tfp_pkg::result_t      head;
    tfp_pkg::fifo_stat_t   fifo_stat;

    // Configuration is always taken; the user must write it only while the parser is idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_value_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            magic_value_reg <= cfg_data;
        end
    end

    // Input register: the held byte is decoded once the queue has room for
    // the largest result group (two items). Ready depends on registers only,
    // so the output side never reaches the input handshake combinationally.
    assign fire     = in_valid_reg && fifo_stat.room2;
    assign rx_ready = !in_valid_reg || fifo_stat.room2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_valid && rx_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    tfp_frame_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .magic_value (magic_value_reg),
        .in_byte     (in_byte_reg),
        .fire        (fire),
        .wr_cnt      (wr_cnt),
        .res0        (res0),
        .res1        (res1)
    );

    tfp_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_cnt (wr_cnt),
        .wr0    (res0),
        .wr1    (res1),
        .pop    (pop),
        .head   (head),
        .stat   (fifo_stat)
    );

    // Output port straight from the queue head.
    assign out_valid    = fifo_stat.not_empty;
    assign pop          = out_valid && out_ready;
    assign field_kind   = head.kind;
    assign field_index  = head.index;
    assign field_value  = head.value;
    assign frame_status = head.status;
    assign result_last  = head.last;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    // Queue never overfills.
    `TFP_ASSERT_IMPLIES(a_fifo_bound, 1'b1,
        fifo_stat.count <= tfp_pkg::RES_CNT_W'(tfp_pkg::RES_DEPTH))
    // Only frame-end items carry a nonzero frame status.
    `TFP_ASSERT_IMPLIES(a_status_only_end, out_valid && field_kind != tfp_pkg::KIND_END,
        frame_status == tfp_pkg::FST_OK)
    // The low servo nibble is never the last item of its byte.
    `TFP_ASSERT_IMPLIES(a_servo_low_not_last,
        out_valid && field_kind == tfp_pkg::KIND_SERVO && !field_index[0], !result_last)
    // The partner of a non-last item is already queued behind it.
    `TFP_ASSERT_NEXT(a_pair_follows, pop && !result_last, out_valid)

endmodule

// ----- bench/tfp_field_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame parser result checker
// Watches the config, byte and result channels of the parser, decodes every
// accepted byte into the field items it must produce and compares each
// accepted result item, field by field, with the oldest decoded one.
// ----------------------------------------------------------------------------
module tfp_field_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [3:0]         field_kind,
    input  logic [4:0]         field_index,
    input  logic signed [15:0] field_value,
    input  logic [1:0]         frame_status,
    input  logic               result_last,
    output int                 mismatch_count,
    output int                 fields_outstanding
);

    tfp_pkg::result_t pending_fields[$];
    tfp_pkg::result_t want;
    logic [7:0]       magic_byte;
    logic [6:0]       frame_pos;
    logic [7:0]       frame_xor;
    logic [7:0]       high_byte;

    function automatic void expect_field(tfp_pkg::kind_t kind, logic [4:0] index,
                                         logic [15:0] value, tfp_pkg::fstat_t status,
                                         logic last);
        tfp_pkg::result_t r;
        r.kind   = kind;
        r.index  = index;
        r.value  = value;
        r.status = status;
        r.last   = last;
        pending_fields.push_back(r);
    endfunction

    // Field items caused by one received byte; advances the frame state.
    task automatic decode_rx_byte(input logic [7:0] b);
        logic [6:0]  off;
        logic [15:0] word;
        word = {high_byte, b} ^ tfp_pkg::WORD_OFFSET;
        if (frame_pos == tfp_pkg::POS_MAGIC)
        begin
            if (b != magic_byte)
            begin
                expect_field(tfp_pkg::KIND_END, '0, '0, tfp_pkg::FST_BAD_MAGIC, 1'b1);
                frame_xor = tfp_pkg::XOR_SEED;
            end
            else
            begin
                frame_xor = tfp_pkg::XOR_SEED ^ b;
                frame_pos = tfp_pkg::POS_STATUS;
            end
        end
        else if (frame_pos >= tfp_pkg::POS_SUM)
        begin
            expect_field(tfp_pkg::KIND_END, '0, '0,
                         (b == frame_xor) ? tfp_pkg::FST_OK : tfp_pkg::FST_BAD_SUM, 1'b1);
            frame_pos = tfp_pkg::POS_MAGIC;
            frame_xor = tfp_pkg::XOR_SEED;
        end
        else
        begin
            frame_xor = frame_xor ^ b;
            if (frame_pos == tfp_pkg::POS_STATUS)
                expect_field(tfp_pkg::KIND_STATUS, '0, {{8{b[7]}}, b}, tfp_pkg::FST_OK, 1'b1);
            else if (frame_pos < tfp_pkg::POS_DIST)
            begin
                off = frame_pos - tfp_pkg::POS_ANGLE;
                if (!off[0])
                    high_byte = b;
                else
                    expect_field(tfp_pkg::KIND_ANGLE, off[5:1], word, tfp_pkg::FST_OK, 1'b1);
            end
            else if (frame_pos < tfp_pkg::POS_SERVO)
                expect_field(tfp_pkg::KIND_DIST, 5'(frame_pos - tfp_pkg::POS_DIST),
                             {8'h00, b}, tfp_pkg::FST_OK, 1'b1);
            else if (frame_pos < tfp_pkg::POS_IMUX)
            begin
                // low nibble first, then high nibble, both unsigned
                off = frame_pos - tfp_pkg::POS_SERVO;
                expect_field(tfp_pkg::KIND_SERVO, {off[3:0], 1'b0}, {12'h000, b[3:0]},
                             tfp_pkg::FST_OK, 1'b0);
                expect_field(tfp_pkg::KIND_SERVO, {off[3:0], 1'b1}, {12'h000, b[7:4]},
                             tfp_pkg::FST_OK, 1'b1);
            end
            else if (frame_pos < tfp_pkg::POS_LOOP)
            begin
                // imu x, imu y, imu status, voltage: two bytes each
                off = frame_pos - tfp_pkg::POS_IMUX;
                if (!off[0])
                    high_byte = b;
                else
                    expect_field(tfp_pkg::kind_t'(tfp_pkg::KIND_IMUX + off[2:1]), '0, word,
                                 tfp_pkg::FST_OK, 1'b1);
            end
            else
                expect_field(tfp_pkg::KIND_LOOP, '0, {8'h00, b}, tfp_pkg::FST_OK, 1'b1);
            frame_pos = frame_pos + 7'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_fields.delete();
            magic_byte         = 8'h00;
            frame_pos          = tfp_pkg::POS_MAGIC;
            frame_xor          = tfp_pkg::XOR_SEED;
            high_byte          = 8'h00;
            mismatch_count     = 0;
            fields_outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_fields.size() == 0)
                begin
                    $error("result item with none expected: kind %0d index %0d value %0d",
                           field_kind, field_index, field_value);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_fields.pop_front();
                    if (field_kind !== want.kind)
                    begin
                        $error("field_kind: expected %0d, actual %0d", want.kind, field_kind);
                        mismatch_count++;
                    end
                    if (field_index !== want.index)
                    begin
                        $error("field_index: expected %0d, actual %0d",
                               want.index, field_index);
                        mismatch_count++;
                    end
                    if (field_value !== want.value)
                    begin
                        $error("field_value: expected %0d, actual %0d",
                               want.value, field_value);
                        mismatch_count++;
                    end
                    if (frame_status !== want.status)
                    begin
                        $error("frame_status: expected %0d, actual %0d",
                               want.status, frame_status);
                        mismatch_count++;
                    end
                    if (result_last !== want.last)
                    begin
                        $error("result_last: expected %0d, actual %0d",
                               want.last, result_last);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                magic_byte = cfg_data;
            if (rx_valid && rx_ready)
                decode_rx_byte(rx_byte);
            fields_outstanding <= pending_fields.size();
        end
    end

endmodule

// ----- bench/tb_telemetry_frame_parser_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame parser testbench
// Streams whole telemetry frames, wrong-magic noise and frames with a bad
// checksum into the parser under several magic byte settings, with random
// gaps and stalls on both sides and one long output stall. A checker module
// beside the parser predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_telemetry_frame_parser_core;

    localparam int FRAME_LEN    = int'(tfp_pkg::POS_SUM) + 1;  // magic through checksum
    localparam int NUM_PHASES   = 5;                  // one magic setting per phase
    localparam int PHASE_BYTES  = 260;                // bytes sent per phase (approx.)
    localparam int IDLE_PCT     = 36;                 // idle chance per cycle, each side
    localparam int HOLD_CYCLES  = 300;                // long output stall
    localparam int DRAIN_CYCLES = 8;                  // settle time after the last item drains
    localparam int QUIET_LIMIT  = 4000;               // cycles with no item moving

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data  = 8'h00;
    logic               rx_valid  = 1'b0;
    logic               rx_ready;
    logic [7:0]         rx_byte   = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         field_kind;
    logic [4:0]         field_index;
    logic signed [15:0] field_value;
    logic [1:0]         frame_status;
    logic               result_last;

    int                 mismatch_count;
    int                 fields_outstanding;

    // Stimulus bookkeeping
    logic [7:0]         cur_magic  = 8'h00;  // magic the parser holds (reset value 0)
    logic [7:0]         frame_head[$];       // fixed bytes right after the magic byte
    int                 phase_bytes;
    logic               steady     = 1'b0;   // no idling on either side
    logic               hold_armed = 1'b0;   // ask the receiver for its long stall
    logic               hold_taken = 1'b0;
    int                 hold_left  = 0;
    int                 quiet      = 0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    telemetry_frame_parser_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .field_kind   (field_kind),
        .field_index  (field_index),
        .field_value  (field_value),
        .frame_status (frame_status),
        .result_last  (result_last)
    );

    tfp_field_checker CHK (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .rx_valid           (rx_valid),
        .rx_ready           (rx_ready),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .field_kind         (field_kind),
        .field_index        (field_index),
        .field_value        (field_value),
        .frame_status       (frame_status),
        .result_last        (result_last),
        .mismatch_count     (mismatch_count),
        .fields_outstanding (fields_outstanding)
    );

    // Receiver: random back-pressure, plus one long stall once armed. The
    // stall is counted here so that the sender keeps offering bytes while
    // the parser's result queue fills and rx_ready drops.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && !hold_taken)
        begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: a stretch with no item moving on any channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && rx_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // Frame payload bytes, leaning on the extremes of the offset-binary
    // and signed decodes.
    function automatic logic [7:0] field_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One byte item. Idle cycles come before the item; valid is only
    // lowered for a gap, never between back-to-back items.
    task automatic send_byte(input logic [7:0] b);
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                rx_valid <= 1'b0;
                @(posedge clk);
            end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_ready !== 1'b1)
            @(posedge clk);
        phase_bytes++;
    endtask

    // Bytes that are never the magic: each one is a wrong-magic frame end
    // and leaves the parser still hunting, so frame alignment is kept.
    task automatic send_noise(input int count);
        logic [7:0] b;
        repeat (count)
        begin
            do
                b = 8'($urandom_range(255));
            while (b == cur_magic);
            send_byte(b);
        end
    endtask

    // Full frame: magic, frame_head bytes then random payload, and the
    // XOR checksum, optionally with one bit flipped.
    task automatic send_frame(input bit bad_sum);
        logic [7:0] body [FRAME_LEN];
        logic [7:0] sum;
        body[0] = cur_magic;
        sum     = tfp_pkg::XOR_SEED ^ cur_magic;
        for (int i = 1; i < FRAME_LEN - 1; i++)
        begin
            body[i] = (i <= frame_head.size()) ? frame_head[i-1] : field_byte();
            sum ^= body[i];
        end
        if (bad_sum)
            sum ^= 8'h01 << $urandom_range(7);
        body[FRAME_LEN-1] = sum;
        frame_head.delete();
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte(body[i]);
    endtask

    // Stop sending, let every expected item drain, then allow for the
    // pipeline to settle since magic and high bytes leave no item behind.
    task automatic wait_idle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (fields_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_magic(input logic [7:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_magic = v;
    endtask

    initial
    begin : stimulus
        int pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: wrong magic bytes against the reset magic of zero, then
        // a frame opening with a negative status and the angle extremes
        // (-32768, 32767, 0, -1) before random payload.
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        frame_head = '{8'h80, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF};
        send_frame(1'b0);
        frame_head = '{8'h7F};
        send_frame(1'b1);

        // Random: mostly good frames, some noise bursts and bad checksums.
        // Phase 2 runs without gaps and carries the long output stall.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1: write_magic(8'hFF);
                2: write_magic(8'($urandom_range(255)));
                3: write_magic(8'h00);
                4: write_magic(8'($urandom_range(255)));
                default: ;
            endcase
            steady <= (ph == 2);
            if (ph == 2)
                hold_armed <= 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                    send_noise($urandom_range(1, 6));
                send_frame(pick == 1);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/tfp_pkg.sv
sv/tfp_frame_decode.sv
sv/tfp_result_fifo.sv
sv/telemetry_frame_parser_core.sv
bench/tfp_field_checker.sv
bench/tb_telemetry_frame_parser_core.sv
